[src/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and constants for the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int PORT_W        = 32;  // fixed width of each operand field
    localparam int KIND_W        = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD = 3'd0,
        KIND_SUB = 3'd1,
        KIND_MUL = 3'd2,
        KIND_DIV = 3'd3,
        KIND_INC = 3'd4
    } kind_t;

    // control bits that travel with each word through the pipeline
    typedef struct packed {
        logic valid;
        logic do_div;
        logic dz;
        logic neg_re;
        logic neg_im;
    } ctl_t;

endpackage

`default_nettype wire

[src/cau_front.sv]
// ----------------------------------------------------------------------------
// cau_front
// Two stages: products and sums, then signed combine to sign/magnitude plus
// the divide denominator.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [cau_pkg::KIND_W-1:0]    in_kind,
    input  wire logic [cau_pkg::PORT_W-1:0]    in_a_real,
    input  wire logic [cau_pkg::PORT_W-1:0]    in_a_imag,
    input  wire logic [cau_pkg::PORT_W-1:0]    in_b_real,
    input  wire logic [cau_pkg::PORT_W-1:0]    in_b_imag,
    output cau_pkg::ctl_t                      out_ctl,
    output logic [2*WORD_BITS-1:0]             out_mag_re,
    output logic [2*WORD_BITS-1:0]             out_mag_im,
    output logic [2*WORD_BITS-1:0]             out_den
);
    import cau_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * WORD_BITS;
    localparam logic signed [W:0] ONE = (W+1)'(1) << FRAC_BITS;

    logic signed [W-1:0]  ar, ai, br, bi;
    kind_t                kind;
    logic signed [PW-1:0] m_rr, m_ii, m_ri, m_ir, m_sr, m_si;
    logic signed [W:0]    as_re, as_im;

    // stage 1 registers
    logic                 v1_reg;
    kind_t                kind1_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic [PW-1:0]        sq_r_reg, sq_i_reg;
    logic signed [W:0]    as_re_reg, as_im_reg;

    assign ar   = in_a_real[W-1:0];
    assign ai   = in_a_imag[W-1:0];
    assign br   = in_b_real[W-1:0];
    assign bi   = in_b_imag[W-1:0];
    assign kind = kind_t'(in_kind);

    assign m_rr = ar * br;
    assign m_ii = ai * bi;
    assign m_ri = ar * bi;
    assign m_ir = ai * br;
    assign m_sr = br * br;
    assign m_si = bi * bi;

    always_comb begin
        case (kind)
            KIND_ADD: begin
                as_re = (W+1)'(ar) + (W+1)'(br);
                as_im = (W+1)'(ai) + (W+1)'(bi);
            end
            KIND_SUB: begin
                as_re = (W+1)'(ar) - (W+1)'(br);
                as_im = (W+1)'(ai) - (W+1)'(bi);
            end
            KIND_INC: begin
                as_re = (W+1)'(ar) + ONE;
                as_im = (W+1)'(ai) + ONE;
            end
            default: begin
                as_re = '0;
                as_im = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            kind1_reg <= kind;
            p_rr_reg  <= m_rr;
            p_ii_reg  <= m_ii;
            p_ri_reg  <= m_ri;
            p_ir_reg  <= m_ir;
            sq_r_reg  <= m_sr;
            sq_i_reg  <= m_si;
            as_re_reg <= as_re;
            as_im_reg <= as_im;
        end
    end

    // stage 2: combine
    logic signed [PW:0] s_re, s_im;
    logic [PW-1:0]      abs_re, abs_im, mag_re_next, mag_im_next, den_next;
    logic               zero_den;
    ctl_t               ctl_next;
    ctl_t               ctl_reg;
    logic [PW-1:0]      mag_re_reg, mag_im_reg, den_reg;

    assign den_next = sq_r_reg + sq_i_reg;
    assign zero_den = (den_next == '0);

    always_comb begin
        case (kind1_reg)
            KIND_ADD, KIND_SUB, KIND_INC: begin
                s_re = (PW+1)'(as_re_reg);
                s_im = (PW+1)'(as_im_reg);
            end
            KIND_MUL: begin
                s_re = (PW+1)'(p_rr_reg) - (PW+1)'(p_ii_reg);
                s_im = (PW+1)'(p_ri_reg) + (PW+1)'(p_ir_reg);
            end
            KIND_DIV: begin
                s_re = (PW+1)'(p_rr_reg) + (PW+1)'(p_ii_reg);
                s_im = (PW+1)'(p_ir_reg) - (PW+1)'(p_ri_reg);
            end
            default: begin
                s_re = '0;
                s_im = '0;
            end
        endcase
        abs_re = s_re[PW] ? PW'(-s_re) : s_re[PW-1:0];
        abs_im = s_im[PW] ? PW'(-s_im) : s_im[PW-1:0];

        ctl_next.valid  = v1_reg;
        ctl_next.do_div = (kind1_reg == KIND_DIV) && !zero_den;
        ctl_next.dz     = (kind1_reg == KIND_DIV) && zero_den;
        ctl_next.neg_re = s_re[PW] && !ctl_next.dz;
        ctl_next.neg_im = s_im[PW] && !ctl_next.dz;

        if (ctl_next.dz) begin
            mag_re_next = '0;
            mag_im_next = '0;
        end else if (kind1_reg == KIND_MUL) begin
            // truncation toward zero on the magnitude
            mag_re_next = abs_re >> FRAC_BITS;
            mag_im_next = abs_im >> FRAC_BITS;
        end else begin
            mag_re_next = abs_re;
            mag_im_next = abs_im;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg.valid <= ctl_next.valid;
        end
        if (en) begin
            ctl_reg.do_div <= ctl_next.do_div;
            ctl_reg.dz     <= ctl_next.dz;
            ctl_reg.neg_re <= ctl_next.neg_re;
            ctl_reg.neg_im <= ctl_next.neg_im;
            mag_re_reg     <= mag_re_next;
            mag_im_reg     <= mag_im_next;
            den_reg        <= den_next;
        end
    end

    assign out_ctl    = ctl_reg;
    assign out_mag_re = mag_re_reg;
    assign out_mag_im = mag_im_reg;
    assign out_den    = den_reg;

endmodule

`default_nettype wire

[src/cau_div.sv]
// ----------------------------------------------------------------------------
// cau_div
// Pipelined restoring divider, one quotient bit per stage for both parts.
// Non-divide words ride through with their magnitude range-checked.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  cau_pkg::ctl_t             in_ctl,
    input  wire logic [2*WORD_BITS-1:0] in_mag_re,
    input  wire logic [2*WORD_BITS-1:0] in_mag_im,
    input  wire logic [2*WORD_BITS-1:0] in_den,
    output cau_pkg::ctl_t             out_ctl,
    output logic                      out_big_re,
    output logic                      out_big_im,
    output logic [WORD_BITS:0]        out_q_re,
    output logic [WORD_BITS:0]        out_q_im
);
    import cau_pkg::*;

    localparam int QB = WORD_BITS + 1;          // quotient bits kept
    localparam int RW = 2 * WORD_BITS;          // remainder / denominator
    localparam int NW = RW + FRAC_BITS;         // scaled numerator
    localparam int TW = NW - QB;                // numerator bits above quotient
    localparam int CW = (TW > RW) ? TW : RW;

    ctl_t          ctl_st   [0:QB];
    logic [RW-1:0] den_st   [0:QB];
    logic [RW-1:0] rem_re_st[0:QB];
    logic [RW-1:0] rem_im_st[0:QB];
    logic [QB-1:0] lo_re_st [0:QB];
    logic [QB-1:0] lo_im_st [0:QB];
    logic          big_re_st[0:QB];
    logic          big_im_st[0:QB];

    // stage 0: initial partial remainder and quotient overflow check
    logic [NW-1:0] num_re, num_im;
    logic [TW-1:0] top_re, top_im;
    logic          big_re_next, big_im_next;
    logic [QB-1:0] lo_re_next, lo_im_next;

    assign num_re = NW'(in_mag_re) << FRAC_BITS;
    assign num_im = NW'(in_mag_im) << FRAC_BITS;
    assign top_re = num_re[NW-1:QB];
    assign top_im = num_im[NW-1:QB];

    always_comb begin
        if (in_ctl.do_div) begin
            big_re_next = CW'(top_re) >= CW'(in_den);
            big_im_next = CW'(top_im) >= CW'(in_den);
            lo_re_next  = num_re[QB-1:0];
            lo_im_next  = num_im[QB-1:0];
        end else begin
            big_re_next = |in_mag_re[RW-1:QB];
            big_im_next = |in_mag_im[RW-1:QB];
            lo_re_next  = in_mag_re[QB-1:0];
            lo_im_next  = in_mag_im[QB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_st[0].valid <= 1'b0;
        end else if (en) begin
            ctl_st[0].valid <= in_ctl.valid;
        end
        if (en) begin
            ctl_st[0].do_div <= in_ctl.do_div;
            ctl_st[0].dz     <= in_ctl.dz;
            ctl_st[0].neg_re <= in_ctl.neg_re;
            ctl_st[0].neg_im <= in_ctl.neg_im;
            den_st[0]        <= in_den;
            rem_re_st[0]     <= RW'(top_re);
            rem_im_st[0]     <= RW'(top_im);
            lo_re_st[0]      <= lo_re_next;
            lo_im_st[0]      <= lo_im_next;
            big_re_st[0]     <= big_re_next;
            big_im_st[0]     <= big_im_next;
        end
    end

    for (genvar i = 1; i <= QB; i++) begin : g_step
        logic [RW:0]   t_re, t_im;
        logic          ge_re, ge_im;
        logic [RW-1:0] rem_re_next, rem_im_next;
        logic [QB-1:0] lo_re_n, lo_im_n;

        // shift next numerator bit in; quotient bit shifts into lo's bottom
        assign t_re  = {rem_re_st[i-1], lo_re_st[i-1][QB-1]};
        assign t_im  = {rem_im_st[i-1], lo_im_st[i-1][QB-1]};
        assign ge_re = t_re >= (RW+1)'(den_st[i-1]);
        assign ge_im = t_im >= (RW+1)'(den_st[i-1]);

        always_comb begin
            if (ctl_st[i-1].do_div) begin
                rem_re_next = ge_re ? RW'(t_re - (RW+1)'(den_st[i-1])) : RW'(t_re);
                rem_im_next = ge_im ? RW'(t_im - (RW+1)'(den_st[i-1])) : RW'(t_im);
                lo_re_n     = {lo_re_st[i-1][QB-2:0], ge_re};
                lo_im_n     = {lo_im_st[i-1][QB-2:0], ge_im};
            end else begin
                rem_re_next = rem_re_st[i-1];
                rem_im_next = rem_im_st[i-1];
                lo_re_n     = lo_re_st[i-1];
                lo_im_n     = lo_im_st[i-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ctl_st[i].valid <= 1'b0;
            end else if (en) begin
                ctl_st[i].valid <= ctl_st[i-1].valid;
            end
            if (en) begin
                ctl_st[i].do_div <= ctl_st[i-1].do_div;
                ctl_st[i].dz     <= ctl_st[i-1].dz;
                ctl_st[i].neg_re <= ctl_st[i-1].neg_re;
                ctl_st[i].neg_im <= ctl_st[i-1].neg_im;
                den_st[i]        <= den_st[i-1];
                rem_re_st[i]     <= rem_re_next;
                rem_im_st[i]     <= rem_im_next;
                lo_re_st[i]      <= lo_re_n;
                lo_im_st[i]      <= lo_im_n;
                big_re_st[i]     <= big_re_st[i-1];
                big_im_st[i]     <= big_im_st[i-1];
            end
        end
    end

    assign out_ctl    = ctl_st[QB];
    assign out_big_re = big_re_st[QB];
    assign out_big_im = big_im_st[QB];
    assign out_q_re   = lo_re_st[QB];
    assign out_q_im   = lo_im_st[QB];

endmodule

`default_nettype wire

[src/cau_sat.sv]
// ----------------------------------------------------------------------------
// cau_sat
// Saturation to the signed word range and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_sat #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  cau_pkg::ctl_t                    in_ctl,
    input  wire logic                        in_big_re,
    input  wire logic                        in_big_im,
    input  wire logic [WORD_BITS:0]          in_q_re,
    input  wire logic [WORD_BITS:0]          in_q_im,
    output logic                             out_valid,
    output logic [cau_pkg::PORT_W-1:0]       out_re,
    output logic [cau_pkg::PORT_W-1:0]       out_im,
    output logic                             out_dz,
    output logic                             out_ovf
);
    import cau_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int QB = WORD_BITS + 1;
    localparam logic [QB-1:0] LIM = QB'(1) << (W - 1);

    logic signed [W-1:0] re_w, im_w;
    logic                sat_re, sat_im;
    logic                valid_reg, dz_reg, ovf_reg;
    logic [PORT_W-1:0]   re_reg, im_reg;

    always_comb begin
        if (in_ctl.neg_re) begin
            sat_re = in_big_re || (in_q_re > LIM);
            re_w   = sat_re ? W'(-LIM) : W'(-in_q_re);
        end else begin
            sat_re = in_big_re || (in_q_re > LIM - QB'(1));
            re_w   = sat_re ? W'(LIM - QB'(1)) : W'(in_q_re);
        end
        if (in_ctl.neg_im) begin
            sat_im = in_big_im || (in_q_im > LIM);
            im_w   = sat_im ? W'(-LIM) : W'(-in_q_im);
        end else begin
            sat_im = in_big_im || (in_q_im > LIM - QB'(1));
            im_w   = sat_im ? W'(LIM - QB'(1)) : W'(in_q_im);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_ctl.valid;
        end
        if (en) begin
            re_reg  <= PORT_W'(re_w);
            im_reg  <= PORT_W'(im_w);
            dz_reg  <= in_ctl.dz;
            ovf_reg <= sat_re || sat_im;
        end
    end

    assign out_valid = valid_reg;
    assign out_re    = re_reg;
    assign out_im    = im_reg;
    assign out_dz    = dz_reg;
    assign out_ovf   = ovf_reg;

endmodule

`default_nettype wire

[src/complex_arith_unit.sv]
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex add, subtract, multiply, divide and increment in signed fixed point.
//
//   channel  tdata (low bit up)                         tuser
//   s_       a_real, a_imag, b_real, b_imag (4 x 32)    kind [2:0]
//   m_       res_real, res_imag (2 x 32)                div_zero, overflow
//
// One word per cycle unless the output stalls; the pipeline depth is set by
// the divider's one quotient bit per stage.
// Synchronous active-low reset clears the valid bits only.
// All stages advance together when the output register is empty or taken.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arith_unit #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [127:0]  s_tdata,   // a_real, a_imag, b_real, b_imag
    input  wire logic [7:0]    s_tuser,   // kind [2:0], rest zero
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [63:0]        m_tdata,   // res_real, res_imag
    output logic [7:0]         m_tuser    // div_zero [0], overflow [1]
);
    import cau_pkg::*;

    logic              adv;
    ctl_t              f_ctl, d_ctl;
    logic [2*WORD_BITS-1:0] f_mag_re, f_mag_im, f_den;
    logic              d_big_re, d_big_im;
    logic [WORD_BITS:0] d_q_re, d_q_im;
    logic [PORT_W-1:0] res_re, res_im;
    logic              res_dz, res_ovf;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    cau_front #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_valid   (s_tvalid),
        .in_kind    (s_tuser[KIND_W-1:0]),
        .in_a_real  (s_tdata[31:0]),
        .in_a_imag  (s_tdata[63:32]),
        .in_b_real  (s_tdata[95:64]),
        .in_b_imag  (s_tdata[127:96]),
        .out_ctl    (f_ctl),
        .out_mag_re (f_mag_re),
        .out_mag_im (f_mag_im),
        .out_den    (f_den)
    );

    cau_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_ctl     (f_ctl),
        .in_mag_re  (f_mag_re),
        .in_mag_im  (f_mag_im),
        .in_den     (f_den),
        .out_ctl    (d_ctl),
        .out_big_re (d_big_re),
        .out_big_im (d_big_im),
        .out_q_re   (d_q_re),
        .out_q_im   (d_q_im)
    );

    cau_sat #(.WORD_BITS(WORD_BITS)) u_sat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_ctl    (d_ctl),
        .in_big_re (d_big_re),
        .in_big_im (d_big_im),
        .in_q_re   (d_q_re),
        .in_q_im   (d_q_im),
        .out_valid (m_tvalid),
        .out_re    (res_re),
        .out_im    (res_im),
        .out_dz    (res_dz),
        .out_ovf   (res_ovf)
    );

    assign m_tdata = {res_im, res_re};
    assign m_tuser = {6'd0, res_ovf, res_dz};

endmodule

`default_nettype wire

[tb/sv/complex_arith_unit_test.sv]
// ----------------------------------------------------------------------------
// complex_arith_unit_test
// Drives operand words through the complex arithmetic unit with random idle
// and stall phases, and checks every result word against a local predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module complex_arith_unit_test;
    import cau_pkg::*;

    localparam int FB        = 16;
    localparam int N_RANDOM  = 1600;
    localparam int WD_LIMIT  = 4000;
    localparam int LAT       = 37;
    localparam logic signed [31:0] WMAX = 32'sh7fffffff;
    localparam logic signed [31:0] WMIN = 32'sh80000000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] ar, ai, br, bi;
    } op_word_t;

    typedef struct packed {
        logic [31:0] re, im;
        logic        dz, ovf;
    } res_word_t;

    typedef struct {
        op_word_t  op;
        logic      has_exp;
        res_word_t exp_res;
    } dir_row_t;

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, m_tready = 0;
    logic [127:0] s_tdata = '0;
    logic [7:0]   s_tuser = '0;
    logic s_tready, m_tvalid;
    logic [63:0] m_tdata;
    logic [7:0]  m_tuser;

    complex_arith_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    res_word_t expected_q[$];
    int  errors = 0;
    int  send_idle = 0, recv_stall = 0;
    int  quiet_cycles = 0;

    // saturate a signed value to the 32-bit word
    function automatic logic [31:0] sat_word(input logic signed [127:0] v, inout logic ovf);
        if (v > WMAX) begin
            ovf = 1; return WMAX;
        end
        if (v < WMIN) begin
            ovf = 1; return WMIN;
        end
        return v[31:0];
    endfunction

    function automatic res_word_t compute_result(input op_word_t op);
        res_word_t r;
        logic signed [127:0] ar, ai, br, bi, pr, pi, den, nr, ni;
        logic ovf;
        ar = $signed(op.ar); ai = $signed(op.ai);
        br = $signed(op.br); bi = $signed(op.bi);
        ovf = 0;
        r = '0;
        case (op.kind)
            KIND_ADD: begin
                r.re = sat_word(ar + br, ovf); r.im = sat_word(ai + bi, ovf);
            end
            KIND_SUB: begin
                r.re = sat_word(ar - br, ovf); r.im = sat_word(ai - bi, ovf);
            end
            KIND_MUL: begin
                // truncation toward zero of the scaled product
                pr = ar * br - ai * bi;
                pi = ar * bi + ai * br;
                r.re = sat_word(pr / (128'sd1 <<< FB), ovf);
                r.im = sat_word(pi / (128'sd1 <<< FB), ovf);
            end
            KIND_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.dz = 1;
                end else begin
                    nr = (ar * br + ai * bi) * (128'sd1 <<< FB);
                    ni = (ai * br - ar * bi) * (128'sd1 <<< FB);
                    r.re = sat_word(nr / den, ovf);
                    r.im = sat_word(ni / den, ovf);
                end
            end
            KIND_INC: begin
                r.re = sat_word(ar + (128'sd1 <<< FB), ovf);
                r.im = sat_word(ai + (128'sd1 <<< FB), ovf);
            end
            default: ;
        endcase
        r.ovf = ovf;
        return r;
    endfunction

    function automatic res_word_t mk_res(input logic [31:0] re, im, input logic dz, ovf);
        res_word_t r;
        r.re = re; r.im = im; r.dz = dz; r.ovf = ovf;
        return r;
    endfunction

    function automatic op_word_t mk_op(input logic [2:0] k,
                                       input logic [31:0] ar, ai, br, bi);
        op_word_t o;
        o.kind = k; o.ar = ar; o.ai = ai; o.br = br; o.bi = bi;
        return o;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? WMAX : WMIN;
            2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 8)) << FB
                                            : -(32'($urandom_range(0, 8)) << FB);
            3: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            4: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    // one word on the input channel; tvalid drops only while idling
    task automatic send_word(input op_word_t op);
        while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {op.bi, op.br, op.ai, op.ar};
        s_tuser  <= {5'd0, op.kind};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(compute_result(op));
    endtask

    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    // receiver side: random stalls and checking
    always @(posedge aclk) begin
        res_word_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = mk_res(m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1]);
                if (expected_q.size() == 0) begin
                    $error("unexpected result word %h", got);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.re !== want.re) begin
                        $error("res_real expected %h got %h", want.re, got.re); errors++;
                    end
                    if (got.im !== want.im) begin
                        $error("res_imag expected %h got %h", want.im, got.im); errors++;
                    end
                    if (got.dz !== want.dz) begin
                        $error("div_zero expected %b got %b", want.dz, got.dz); errors++;
                    end
                    if (got.ovf !== want.ovf) begin
                        $error("overflow expected %b got %b", want.ovf, got.ovf); errors++;
                    end
                end
            end
            m_tready <= !(recv_stall > 0 && $urandom_range(0, 99) < recv_stall);
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WD_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    dir_row_t dir_rows[$];

    task automatic add_row(input op_word_t op, input logic has, input res_word_t r);
        dir_row_t d;
        d.op = op; d.has_exp = has; d.exp_res = r;
        dir_rows.push_back(d);
    endtask

    initial begin
        op_word_t  op;
        res_word_t none;
        int phase;
        none = '0;

        add_row(mk_op(KIND_ADD, 0, 0, 0, 0), 1, mk_res(0, 0, 0, 0));
        add_row(mk_op(KIND_ADD, WMAX, WMIN, 1, -1), 1, mk_res(WMAX, WMIN, 0, 1));
        add_row(mk_op(KIND_ADD, 32'h00010000, 32'h00020000, 32'h00030000, 0), 1,
                mk_res(32'h00040000, 32'h00020000, 0, 0));
        add_row(mk_op(KIND_SUB, WMIN, WMAX, 1, -1), 1, mk_res(WMIN, WMAX, 0, 1));
        add_row(mk_op(KIND_SUB, 5, 7, 5, 7), 1, mk_res(0, 0, 0, 0));
        add_row(mk_op(KIND_MUL, 32'h00010000, 0, 32'h00010000, 0), 1,
                mk_res(32'h00010000, 0, 0, 0));
        add_row(mk_op(KIND_MUL, WMAX, WMAX, WMAX, WMAX), 0, none);
        add_row(mk_op(KIND_MUL, WMIN, WMIN, WMIN, WMIN), 0, none);
        add_row(mk_op(KIND_MUL, -3, 5, 7, -1), 0, none);
        add_row(mk_op(KIND_DIV, WMAX, WMIN, 0, 0), 1, mk_res(0, 0, 1, 0));
        add_row(mk_op(KIND_DIV, 32'h00020000, 0, 32'h00010000, 0), 1,
                mk_res(32'h00020000, 0, 0, 0));
        add_row(mk_op(KIND_DIV, WMAX, WMAX, 1, 0), 1, mk_res(WMAX, WMAX, 0, 1));
        add_row(mk_op(KIND_DIV, WMIN, WMIN, WMIN, WMIN), 0, none);
        add_row(mk_op(KIND_DIV, WMIN, WMAX, 1, 1), 0, none);
        add_row(mk_op(KIND_DIV, -7, 3, 0, 32'h00030000), 0, none);
        add_row(mk_op(KIND_INC, 0, 0, WMAX, WMIN), 1,
                mk_res(32'h00010000, 32'h00010000, 0, 0));
        add_row(mk_op(KIND_INC, WMAX, 32'hffff0000, 0, 0), 1, mk_res(WMAX, 0, 0, 1));
        add_row(mk_op(KIND_INC, WMIN, WMIN, 0, 0), 0, none);
        add_row(mk_op(3'd5, WMAX, WMAX, WMAX, WMAX), 1, mk_res(0, 0, 0, 0));
        add_row(mk_op(3'd6, 1, 2, 0, 0), 1, mk_res(0, 0, 0, 0));
        add_row(mk_op(3'd7, WMIN, WMIN, 0, 0), 1, mk_res(0, 0, 0, 0));

        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].has_exp && compute_result(dir_rows[i].op) !== dir_rows[i].exp_res) begin
                $error("directed row %0d table value %h disagrees with predictor",
                       i, dir_rows[i].exp_res);
                errors++;
            end
            send_word(dir_rows[i].op);
        end

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 59; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 59; end
                default: begin send_idle = 31; recv_stall = 31; end
            endcase
            repeat (N_RANDOM / 4) begin
                op.kind = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                       : 3'($urandom_range(0, 4));
                op.ar = rand_operand(); op.ai = rand_operand();
                op.br = rand_operand(); op.bi = rand_operand();
                send_word(op);
            end
        end
        s_tvalid <= 0;

        wait_drained();
        repeat (LAT + 10) @(posedge aclk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
